/* sv/bsd_pkg.sv */
// Package for the BMP stream decoder: sizes, result and error codes, and the
// structs passed between the front end, the parser and the result queue.
// No dependencies.
package bsd_pkg;

    // Largest image the decoder accepts
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    // Header layout
    localparam int HDR_LEN = 54;
    localparam logic [31:0] HDR_LEN_W  = 32'(HDR_LEN);
    localparam logic [31:0] HDR_LAST_W = 32'(HDR_LEN - 1);
    localparam logic [15:0] DEPTH_24   = 16'd24;
    localparam logic [15:0] DEPTH_32   = 16'd32;

    // Counter and port widths
    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DIM_W = 13;
    localparam int PIX_W = 12;

    // Queue sizing, shared by the byte queue and the result queue
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        FLD_NONE,
        FLD_OFFSET,
        FLD_WIDTH,
        FLD_HEIGHT,
        FLD_DEPTH
    } hdr_field_t;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_PIXEL  = 2'd1,
        KIND_ERROR  = 2'd2
    } result_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_SHORT = 2'd1,
        ERR_DEPTH = 2'd2,
        ERR_RANGE = 2'd3
    } error_code_t;

    // One classified input byte
    typedef struct packed {
        logic [7:0]  data;
        logic        file_start;
        logic        file_end;
        logic [31:0] pos;
        hdr_field_t  field;
        logic [1:0]  lane;
        logic        hdr_last;
    } byte_item_t;

    // Head of the byte queue as seen by the parser
    typedef struct packed {
        logic       valid;
        byte_item_t item;
    } byte_head_t;

    // One result item
    typedef struct packed {
        result_kind_t kind;
        error_code_t  err;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] y;
        logic [7:0]   red;
        logic [7:0]   green;
        logic [7:0]   blue;
        logic         last;
    } result_t;

    // Parser to result queue write
    typedef struct packed {
        logic    push;
        result_t res;
    } result_push_t;

endpackage

/* sv/bsd_front.sv */
// Front end of the BMP stream decoder: tracks the file position, tags header
// bytes with their field and byte lane, and holds every byte in a short queue.
// Depends on bsd_pkg.
module bsd_front
    import bsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] data_byte,
    input  logic       file_start,
    input  logic       file_end,
    input  logic       push,
    output logic       full,
    input  logic       head_pop,
    output byte_head_t head
);

    logic [31:0]      pos_reg;
    logic [31:0]      pos_next;
    logic [31:0]      cur_pos;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    byte_item_t       entry_reg [QUEUE_DEPTH];
    byte_item_t       new_item;
    logic             push_acc;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign push_acc = push && !full;

    // File position, restarted by file_start, saturating at the top
    always_comb
    begin
        cur_pos  = file_start ? 32'd0 : pos_reg;
        pos_next = (cur_pos == 32'hFFFF_FFFF) ? cur_pos : cur_pos + 32'd1;
    end

    // Classify the byte by its place in the header
    always_comb
    begin
        new_item            = '0;
        new_item.data       = data_byte;
        new_item.file_start = file_start;
        new_item.file_end   = file_end;
        new_item.pos        = cur_pos;
        new_item.hdr_last   = (cur_pos == HDR_LAST_W);
        new_item.field      = FLD_NONE;
        new_item.lane       = cur_pos[1:0] - 2'd2;
        if (cur_pos inside {[32'd10:32'd13]})
        begin
            new_item.field = FLD_OFFSET;
        end
        else if (cur_pos inside {[32'd18:32'd21]})
        begin
            new_item.field = FLD_WIDTH;
        end
        else if (cur_pos inside {[32'd22:32'd25]})
        begin
            new_item.field = FLD_HEIGHT;
        end
        else if (cur_pos inside {[32'd28:32'd29]})
        begin
            new_item.field = FLD_DEPTH;
            new_item.lane  = cur_pos[1:0];
        end
    end

    // Position counter and queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_acc)
            begin
                pos_reg    <= pos_next;
                wr_ptr_reg <= PTR_W'((32'(wr_ptr_reg) + 1) % QUEUE_DEPTH);
            end
            if (head_pop)
            begin
                rd_ptr_reg <= PTR_W'((32'(rd_ptr_reg) + 1) % QUEUE_DEPTH);
            end
            if (push_acc && !head_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (!push_acc && head_pop)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push_acc)
        begin
            entry_reg[wr_ptr_reg] <= new_item;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = entry_reg[rd_ptr_reg];

endmodule

/* sv/bsd_parser.sv */
// Back end of the BMP stream decoder: header assembly and checks, offset skip,
// pixel walk with row padding, one result per byte at most.
// Depends on bsd_pkg.
module bsd_parser
    import bsd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  byte_head_t   head,
    output logic         head_pop,
    input  logic         res_ready,
    output result_push_t res_out
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SKIP,
        PH_PIXELS,
        PH_PAD,
        PH_IDLE
    } phase_t;

    phase_t           phase_reg,  phase_next,  cur_phase;
    logic [31:0]      offset_reg, offset_next, cur_offset;
    logic [31:0]      width_reg,  width_next,  cur_width;
    logic [31:0]      height_reg, height_next, cur_height;
    logic [15:0]      depth_reg,  depth_next,  cur_depth;
    logic [COL_W-1:0] col_reg,    col_next,    cur_col;
    logic [ROW_W-1:0] row_reg,    row_next,    cur_row;
    logic [1:0]       bip_reg,    bip_next,    cur_bip;
    logic [1:0]       pad_reg,    pad_next,    cur_pad;
    logic [7:0]       blue_reg,   blue_next,   cur_blue;
    logic [7:0]       green_reg,  green_next,  cur_green;

    byte_item_t       it;
    logic             go;
    logic             bpp4;
    logic             group_end;
    logic [COL_W:0]   col_inc;
    logic [ROW_W:0]   row_inc;
    logic [31:0]      lane_word;
    logic [15:0]      lane_half;

    assign it       = head.item;
    assign go       = head.valid && res_ready;
    assign head_pop = go;

    // View of the state for this byte; file_start restarts the parser
    always_comb
    begin
        if (it.file_start)
        begin
            cur_phase  = PH_HEADER;
            cur_offset = '0;
            cur_width  = '0;
            cur_height = '0;
            cur_depth  = '0;
            cur_col    = '0;
            cur_row    = '0;
            cur_bip    = '0;
            cur_pad    = '0;
            cur_blue   = '0;
            cur_green  = '0;
        end
        else
        begin
            cur_phase  = phase_reg;
            cur_offset = offset_reg;
            cur_width  = width_reg;
            cur_height = height_reg;
            cur_depth  = depth_reg;
            cur_col    = col_reg;
            cur_row    = row_reg;
            cur_bip    = bip_reg;
            cur_pad    = pad_reg;
            cur_blue   = blue_reg;
            cur_green  = green_reg;
        end
    end

    assign bpp4      = (cur_depth == DEPTH_32);
    assign group_end = bpp4 ? (cur_bip == 2'd3) : (cur_bip == 2'd2);
    assign col_inc   = {1'b0, cur_col} + (COL_W+1)'(1);
    assign row_inc   = {1'b0, cur_row} + (ROW_W+1)'(1);
    assign lane_word = 32'(it.data) << {it.lane, 3'b000};
    assign lane_half = 16'(it.data) << {it.lane[0], 3'b000};

    // Next state and result
    always_comb
    begin
        phase_next  = cur_phase;
        offset_next = cur_offset;
        width_next  = cur_width;
        height_next = cur_height;
        depth_next  = cur_depth;
        col_next    = cur_col;
        row_next    = cur_row;
        bip_next    = cur_bip;
        pad_next    = cur_pad;
        blue_next   = cur_blue;
        green_next  = cur_green;
        res_out     = '0;

        case (cur_phase)
            PH_HEADER:
            begin
                case (it.field)
                    FLD_OFFSET: offset_next = cur_offset | lane_word;
                    FLD_WIDTH:  width_next  = cur_width  | lane_word;
                    FLD_HEIGHT: height_next = cur_height | lane_word;
                    FLD_DEPTH:  depth_next  = cur_depth  | lane_half;
                    default:    ;
                endcase
                if (it.hdr_last)
                begin
                    res_out.push = 1'b1;
                    if (depth_next != DEPTH_24 && depth_next != DEPTH_32)
                    begin
                        res_out.res.kind = KIND_ERROR;
                        res_out.res.err  = ERR_DEPTH;
                        phase_next       = PH_IDLE;
                    end
                    else if (offset_next < HDR_LEN_W ||
                             width_next > 32'(MAX_WIDTH) ||
                             height_next > 32'(MAX_HEIGHT))
                    begin
                        res_out.res.kind = KIND_ERROR;
                        res_out.res.err  = ERR_RANGE;
                        phase_next       = PH_IDLE;
                    end
                    else
                    begin
                        res_out.res.kind   = KIND_HEADER;
                        res_out.res.width  = DIM_W'(width_next);
                        res_out.res.height = DIM_W'(height_next);
                        if (width_next == '0 || height_next == '0)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else if (offset_next == HDR_LEN_W)
                        begin
                            phase_next = PH_PIXELS;
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                end
                else if (it.file_end)
                begin
                    res_out.push     = 1'b1;
                    res_out.res.kind = KIND_ERROR;
                    res_out.res.err  = ERR_SHORT;
                end
            end
            PH_SKIP:
            begin
                if ({1'b0, it.pos} + 33'd1 == {1'b0, cur_offset})
                begin
                    phase_next = PH_PIXELS;
                end
            end
            PH_PIXELS:
            begin
                case (cur_bip)
                    2'd0: blue_next  = it.data;
                    2'd1: green_next = it.data;
                    2'd2:
                    begin
                        // pixel goes out on its red byte
                        res_out.push      = 1'b1;
                        res_out.res.kind  = KIND_PIXEL;
                        res_out.res.x     = PIX_W'(cur_col);
                        res_out.res.y     = PIX_W'(cur_row);
                        res_out.res.red   = it.data;
                        res_out.res.green = cur_green;
                        res_out.res.blue  = cur_blue;
                        res_out.res.last  = (32'(col_inc) == cur_width) &&
                                            (32'(row_inc) == cur_height);
                    end
                    default: ;
                endcase
                if (group_end)
                begin
                    bip_next = '0;
                    if (32'(col_inc) >= cur_width)
                    begin
                        col_next = '0;
                        row_next = ROW_W'(row_inc);
                        if (32'(row_inc) >= cur_height)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            // 24-bit rows pad by width mod 4, 32-bit rows never
                            pad_next = bpp4 ? 2'd0 : cur_width[1:0];
                            if (pad_next != 2'd0)
                            begin
                                phase_next = PH_PAD;
                            end
                        end
                    end
                    else
                    begin
                        col_next = COL_W'(col_inc);
                    end
                end
                else
                begin
                    bip_next = cur_bip + 2'd1;
                end
            end
            PH_PAD:
            begin
                if (cur_pad != 2'd0)
                begin
                    pad_next = cur_pad - 2'd1;
                end
                if (pad_next == 2'd0)
                begin
                    phase_next = PH_PIXELS;
                end
            end
            default: ;
        endcase

        if (it.file_end)
        begin
            phase_next = PH_IDLE;
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            offset_reg <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            depth_reg  <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            bip_reg    <= '0;
            pad_reg    <= '0;
            blue_reg   <= '0;
            green_reg  <= '0;
        end
        else if (go)
        begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            depth_reg  <= depth_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            bip_reg    <= bip_next;
            pad_reg    <= pad_next;
            blue_reg   <= blue_next;
            green_reg  <= green_next;
        end
    end

endmodule

/* sv/bsd_result_queue.sv */
// Result queue of the BMP stream decoder: holds finished results until the
// consumer pops them. Depends on bsd_pkg.
module bsd_result_queue
    import bsd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         go,
    input  result_push_t res_in,
    output logic         ready,
    input  logic         pop,
    output logic         empty,
    output result_t      head
);

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    result_t          entry_reg [QUEUE_DEPTH];
    logic             wr_en;
    logic             rd_en;

    assign ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign wr_en = go && res_in.push;
    assign rd_en = pop && !empty;

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= PTR_W'((32'(wr_ptr_reg) + 1) % QUEUE_DEPTH);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= PTR_W'((32'(rd_ptr_reg) + 1) % QUEUE_DEPTH);
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (!wr_en && rd_en)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= res_in.res;
        end
    end

    assign head = entry_reg[rd_ptr_reg];

endmodule

/* sv/bmp_stream_decoder_unit.sv */
// BMP stream decoder, one file byte per transaction, at most one result each.
// Throughput: one byte per cycle while the result queue has room, set by the
// parser's per-byte state update. An accepted byte is registered in the byte
// queue, then the parser writes its result into the result queue.
// Reset: rst_n clears both queues and returns the parser to the header phase.
// Depends on bsd_pkg, bsd_front, bsd_parser, bsd_result_queue.
module bmp_stream_decoder_unit
    import bsd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       data_byte,
    input  logic             file_start,
    input  logic             file_end,
    input  logic             push,
    output logic             full,
    output logic [1:0]       result_kind,
    output logic [1:0]       error_code,
    output logic [DIM_W-1:0] image_width,
    output logic [DIM_W-1:0] image_height,
    output logic [PIX_W-1:0] pixel_x,
    output logic [PIX_W-1:0] pixel_y,
    output logic [7:0]       red,
    output logic [7:0]       green,
    output logic [7:0]       blue,
    output logic             last_pixel,
    output logic             empty,
    input  logic             pop
);

    byte_head_t   head;
    logic         head_pop;
    logic         res_ready;
    result_push_t res_push;
    result_t      res_head;

    // Byte tagging and input queue
    bsd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_byte  (data_byte),
        .file_start (file_start),
        .file_end   (file_end),
        .push       (push),
        .full       (full),
        .head_pop   (head_pop),
        .head       (head)
    );

    // Parser
    bsd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .head_pop  (head_pop),
        .res_ready (res_ready),
        .res_out   (res_push)
    );

    // Output queue
    bsd_result_queue u_results (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (head_pop),
        .res_in (res_push),
        .ready  (res_ready),
        .pop    (pop),
        .empty  (empty),
        .head   (res_head)
    );

    assign result_kind  = res_head.kind;
    assign error_code   = res_head.err;
    assign image_width  = res_head.width;
    assign image_height = res_head.height;
    assign pixel_x      = res_head.x;
    assign pixel_y      = res_head.y;
    assign red          = res_head.red;
    assign green        = res_head.green;
    assign blue         = res_head.blue;
    assign last_pixel   = res_head.last;

endmodule

/* sv/bsd_checker.sv */
// Port-level checks for the BMP stream decoder, bound to the top level.
// Depends on bsd_pkg and bmp_stream_decoder_unit.
module bsd_checker
    import bsd_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic [7:0]       data_byte,
    input logic             file_start,
    input logic             file_end,
    input logic             push,
    input logic             full,
    input logic [1:0]       result_kind,
    input logic [1:0]       error_code,
    input logic [DIM_W-1:0] image_width,
    input logic [DIM_W-1:0] image_height,
    input logic [PIX_W-1:0] pixel_x,
    input logic [PIX_W-1:0] pixel_y,
    input logic [7:0]       red,
    input logic [7:0]       green,
    input logic [7:0]       blue,
    input logic             last_pixel,
    input logic             empty,
    input logic             pop
);

    // Nothing waits on the result side while reset is held
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result queue not empty in reset");

    // A waiting result holds until it is popped
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result_kind) && $stable(pixel_x)
                              && $stable(red)))
        else $error("waiting result changed before pop");

    // Error code is set exactly on error results
    a_error_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((result_kind == KIND_ERROR) == (error_code != ERR_NONE)))
        else $error("error code does not match result kind");

    // Pixel fields are zero on header and error results
    a_pixel_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind != KIND_PIXEL) |->
            (pixel_x == '0 && pixel_y == '0 && red == '0 && green == '0 &&
             blue == '0 && !last_pixel))
        else $error("pixel fields set on a non-pixel result");

endmodule

bind bmp_stream_decoder_unit bsd_checker u_bsd_checker (.*);

/* sim/bmp_stream_decoder_checker.sv */
// Checker for the BMP stream decoder: watches the byte and result queues,
// predicts each result from the accepted bytes and compares field by field.
// Depends on bsd_pkg.
`timescale 1ns / 100ps

module bmp_stream_decoder_checker
    import bsd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       data_byte,
    input  logic             file_start,
    input  logic             file_end,
    input  logic             push,
    input  logic             full,
    input  logic [1:0]       result_kind,
    input  logic [1:0]       error_code,
    input  logic [DIM_W-1:0] image_width,
    input  logic [DIM_W-1:0] image_height,
    input  logic [PIX_W-1:0] pixel_x,
    input  logic [PIX_W-1:0] pixel_y,
    input  logic [7:0]       red,
    input  logic [7:0]       green,
    input  logic [7:0]       blue,
    input  logic             last_pixel,
    input  logic             empty,
    input  logic             pop,
    output int               results_owed,
    output int               mismatch_count
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SKIP,
        PH_PIXELS,
        PH_PAD,
        PH_IDLE
    } parse_phase_t;

    // Shadow parser state; counters kept at 32 bits so row wrap never hides an end
    parse_phase_t phase;
    logic [31:0]  pos;
    logic [31:0]  pix_offset;
    logic [31:0]  hdr_width;
    logic [31:0]  hdr_height;
    logic [15:0]  depth;
    logic [31:0]  col;
    logic [31:0]  row;
    logic [1:0]   lane;
    logic [1:0]   pad_left;
    logic [7:0]   blue_hold;
    logic [7:0]   green_hold;

    result_t owed[$];
    int      error_tally;

    task automatic clear_parser();
        phase      = PH_HEADER;
        pos        = '0;
        pix_offset = '0;
        hdr_width  = '0;
        hdr_height = '0;
        depth      = '0;
        col        = '0;
        row        = '0;
        lane       = '0;
        pad_left   = '0;
        blue_hold  = '0;
        green_hold = '0;
    endtask

    function automatic logic [31:0] bytes_per_pixel();
        return (depth == DEPTH_32) ? 32'd4 : 32'd3;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        error_tally++;
    endtask

    // Header complete: validate and pick the next phase
    task automatic finish_header(inout result_t r);
        if (depth != DEPTH_24 && depth != DEPTH_32) begin
            r.kind = KIND_ERROR;
            r.err  = ERR_DEPTH;
            phase  = PH_IDLE;
        end else if (pix_offset < HDR_LEN_W || hdr_width > 32'(MAX_WIDTH) ||
                     hdr_height > 32'(MAX_HEIGHT)) begin
            r.kind = KIND_ERROR;
            r.err  = ERR_RANGE;
            phase  = PH_IDLE;
        end else begin
            r.kind   = KIND_HEADER;
            r.width  = hdr_width[DIM_W-1:0];
            r.height = hdr_height[DIM_W-1:0];
            if (hdr_width == 0 || hdr_height == 0)
                phase = PH_IDLE;
            else if (pix_offset == HDR_LEN_W)
                phase = PH_PIXELS;
            else
                phase = PH_SKIP;
        end
    endtask

    // Pixel group done: advance column, row and padding
    task automatic close_group();
        logic [31:0] row_bytes;
        lane = '0;
        if (col + 1 >= hdr_width) begin
            col = '0;
            row++;
            if (row >= hdr_height) begin
                phase = PH_IDLE;
            end else begin
                row_bytes = bytes_per_pixel() * hdr_width;
                pad_left  = 2'(3'd4 - 3'(row_bytes[1:0]));
                if (pad_left != 0)
                    phase = PH_PAD;
            end
        end else begin
            col++;
        end
    endtask

    // One accepted byte: update shadow state, queue the result it causes
    task automatic decode_byte(input logic [7:0] b, input logic start, input logic stop);
        logic [31:0] p;
        result_t     r;
        logic        emit;
        r    = '0;
        emit = 1'b0;
        if (start)
            clear_parser();
        p = pos;
        case (phase)
            PH_HEADER:
            begin
                if (p >= 10 && p <= 13)
                    pix_offset[8*(p-10) +: 8] = b;
                else if (p >= 18 && p <= 21)
                    hdr_width[8*(p-18) +: 8] = b;
                else if (p >= 22 && p <= 25)
                    hdr_height[8*(p-22) +: 8] = b;
                else if (p >= 28 && p <= 29)
                    depth[8*(p-28) +: 8] = b;
                if (p == HDR_LAST_W) begin
                    finish_header(r);
                    emit = 1'b1;
                end else if (stop) begin
                    r.kind = KIND_ERROR;
                    r.err  = ERR_SHORT;
                    emit   = 1'b1;
                end
            end
            PH_SKIP:
            begin
                if ({1'b0, p} + 33'd1 == {1'b0, pix_offset})
                    phase = PH_PIXELS;
            end
            PH_PIXELS:
            begin
                if (lane == 2'd0) begin
                    blue_hold = b;
                end else if (lane == 2'd1) begin
                    green_hold = b;
                end else if (lane == 2'd2) begin
                    r.kind  = KIND_PIXEL;
                    r.x     = col[PIX_W-1:0];
                    r.y     = row[PIX_W-1:0];
                    r.red   = b;
                    r.green = green_hold;
                    r.blue  = blue_hold;
                    r.last  = (col + 1 == hdr_width) && (row + 1 == hdr_height);
                    emit    = 1'b1;
                end
                if (32'(lane) + 1 >= bytes_per_pixel())
                    close_group();
                else
                    lane++;
            end
            PH_PAD:
            begin
                if (pad_left > 0)
                    pad_left--;
                if (pad_left == 0)
                    phase = PH_PIXELS;
            end
            default:
            begin
            end
        endcase
        if (pos != 32'hFFFF_FFFF)
            pos++;
        if (stop)
            phase = PH_IDLE;
        if (emit)
            owed.push_back(r);
    endtask

    // Predict on byte transactions, compare on result transactions
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            clear_parser();
            owed.delete();
            error_tally = 0;
            results_owed   <= 0;
            mismatch_count <= 0;
        end else begin
            if (push && !full)
                decode_byte(data_byte, file_start, file_end);
            if (pop && !empty) begin
                if (owed.size() == 0) begin
                    flag_mismatch("result kind with nothing owed", 32'(result_kind), 0);
                end else begin
                    result_t want;
                    want = owed.pop_front();
                    if (result_kind !== want.kind)
                        flag_mismatch("result_kind", 32'(result_kind), 32'(want.kind));
                    if (error_code !== want.err)
                        flag_mismatch("error_code", 32'(error_code), 32'(want.err));
                    if (image_width !== want.width)
                        flag_mismatch("image_width", 32'(image_width), 32'(want.width));
                    if (image_height !== want.height)
                        flag_mismatch("image_height", 32'(image_height), 32'(want.height));
                    if (pixel_x !== want.x)
                        flag_mismatch("pixel_x", 32'(pixel_x), 32'(want.x));
                    if (pixel_y !== want.y)
                        flag_mismatch("pixel_y", 32'(pixel_y), 32'(want.y));
                    if (red !== want.red)
                        flag_mismatch("red", 32'(red), 32'(want.red));
                    if (green !== want.green)
                        flag_mismatch("green", 32'(green), 32'(want.green));
                    if (blue !== want.blue)
                        flag_mismatch("blue", 32'(blue), 32'(want.blue));
                    if (last_pixel !== want.last)
                        flag_mismatch("last_pixel", 32'(last_pixel), 32'(want.last));
                end
            end
            results_owed   <= owed.size();
            mismatch_count <= error_tally;
        end
    end

endmodule

/* sim/bmp_stream_decoder_unit_test.sv */
// Testbench top for bmp_stream_decoder_unit: builds BMP byte streams, drives the
// byte queue, pops results with random stalls and gives the verdict.
// Depends on bsd_pkg, bmp_stream_decoder_unit and bmp_stream_decoder_checker.
`timescale 1ns / 100ps

module bmp_stream_decoder_unit_test;
    import bsd_pkg::*;

    localparam int RANDOM_ITEMS = 1550;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        logic [7:0] value;
        logic       opens;
        logic       closes;
    } file_byte_t;

    logic             clk        = 1'b0;
    logic             rst_n      = 1'b1;
    logic [7:0]       data_byte  = '0;
    logic             file_start = 1'b0;
    logic             file_end   = 1'b0;
    logic             push       = 1'b0;
    logic             pop        = 1'b0;
    logic             full;
    logic             empty;
    logic [1:0]       result_kind;
    logic [1:0]       error_code;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic             last_pixel;
    int               results_owed;
    int               mismatch_count;

    file_byte_t stream[$];
    int         items_sent = 0;
    int         idle_cycles = 0;
    int         stall_left = 0;
    int         calm_left = 0;

    always #2 clk = ~clk;

    bmp_stream_decoder_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_byte    (data_byte),
        .file_start   (file_start),
        .file_end     (file_end),
        .push         (push),
        .full         (full),
        .result_kind  (result_kind),
        .error_code   (error_code),
        .image_width  (image_width),
        .image_height (image_height),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .last_pixel   (last_pixel),
        .empty        (empty),
        .pop          (pop)
    );

    bmp_stream_decoder_checker decode_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .data_byte      (data_byte),
        .file_start     (file_start),
        .file_end       (file_end),
        .push           (push),
        .full           (full),
        .result_kind    (result_kind),
        .error_code     (error_code),
        .image_width    (image_width),
        .image_height   (image_height),
        .pixel_x        (pixel_x),
        .pixel_y        (pixel_y),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .last_pixel     (last_pixel),
        .empty          (empty),
        .pop            (pop),
        .results_owed   (results_owed),
        .mismatch_count (mismatch_count)
    );

    function automatic bit chance(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // Mostly short pauses, a few long ones
    function automatic int idle_length();
        return chance(85) ? int'($urandom_range(1, 3)) : int'($urandom_range(8, 40));
    endfunction

    task automatic add_byte(input logic [7:0] d, input logic s, input logic e);
        stream.push_back('{d, s, e});
    endtask

    task automatic add_filler(input int n);
        repeat (n) add_byte(8'($urandom), 1'b0, 1'b0);
    endtask

    // 54-byte header with random bytes around the decoded fields
    task automatic add_header(input logic [31:0] offset, input logic [31:0] w,
                              input logic [31:0] h, input logic [15:0] depth);
        logic [7:0] hdr [0:53];
        for (int i = 0; i < HDR_LEN; i++)
            hdr[i] = 8'($urandom);
        if (chance(75)) begin
            hdr[0] = 8'h42;
            hdr[1] = 8'h4D;
        end
        for (int k = 0; k < 4; k++) begin
            hdr[10+k] = offset[8*k +: 8];
            hdr[18+k] = w[8*k +: 8];
            hdr[22+k] = h[8*k +: 8];
        end
        hdr[28] = depth[7:0];
        hdr[29] = depth[15:8];
        for (int i = 0; i < HDR_LEN; i++)
            add_byte(hdr[i], i == 0, 1'b0);
    endtask

    // Rows of pixel groups, each padded to 4 bytes; the last row only when last_pad is set
    task automatic add_pixels(input int w, input int h, input int bpp, input bit last_pad);
        int pad;
        pad = (4 - (w * bpp) % 4) % 4;
        for (int r = 0; r < h; r++) begin
            add_filler(w * bpp);
            if (r < h - 1 || last_pad)
                add_filler(pad);
        end
    endtask

    task automatic build_valid_image();
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] offset;
        logic [15:0] depth;
        int          cut;
        depth  = chance(50) ? DEPTH_24 : DEPTH_32;
        w      = chance(85) ? $urandom_range(1, 6) : $urandom_range(7, 40);
        h      = $urandom_range(1, 5);
        offset = chance(50) ? HDR_LEN_W : HDR_LEN_W + $urandom_range(1, 8);
        add_header(offset, w, h, depth);
        add_filler(int'(offset) - HDR_LEN);
        add_pixels(int'(w), int'(h), (depth == DEPTH_32) ? 4 : 3, chance(50));
        // sometimes cut short after the header, in the offset gap or the pixel data
        if (chance(20)) begin
            cut = $urandom_range(HDR_LEN + 1, stream.size());
            while (stream.size() > cut)
                void'(stream.pop_back());
        end
    endtask

    // One file of a randomly chosen case, end mark and trailing junk sometimes included
    task automatic build_file();
        int          pick;
        int          len;
        bit          closed;
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] offset;
        logic [15:0] depth;
        pick   = $urandom_range(0, 99);
        w      = $urandom_range(1, 6);
        h      = $urandom_range(1, 4);
        depth  = chance(50) ? DEPTH_24 : DEPTH_32;
        offset = HDR_LEN_W;
        if (pick < 55) begin
            build_valid_image();
        end else if (pick < 61) begin
            // empty image
            case ($urandom_range(0, 2))
                0: w = '0;
                1: h = '0;
                default:
                begin
                    w = '0;
                    h = '0;
                end
            endcase
            add_header(offset, w, h, depth);
            add_filler($urandom_range(0, 6));
        end else if (pick < 68) begin
            // unsupported depth, sometimes with a bad offset as well
            case ($urandom_range(0, 5))
                0: depth = 16'd0;
                1: depth = 16'd1;
                2: depth = 16'd16;
                3: depth = 16'd23;
                4: depth = 16'd33;
                default: depth = 16'($urandom);
            endcase
            if (depth == DEPTH_24 || depth == DEPTH_32)
                depth ^= 16'h0100;
            if (chance(30))
                offset = $urandom_range(0, HDR_LEN - 1);
            add_header(offset, w, h, depth);
            add_filler($urandom_range(0, 6));
        end else if (pick < 76) begin
            // offset or size out of range
            case ($urandom_range(0, 3))
                0: offset = $urandom_range(0, HDR_LEN - 1);
                1: w = chance(50) ? 32'(MAX_WIDTH + 1) : {1'b1, 31'($urandom)};
                2: h = chance(50) ? 32'(MAX_HEIGHT + 1) : 32'hFFFF_FFFF - $urandom_range(0, 500);
                default: w = 32'($urandom) | 32'h0001_0000;
            endcase
            add_header(offset, w, h, depth);
            add_filler($urandom_range(0, 6));
        end else if (pick < 80) begin
            // largest accepted size, only the first bytes of pixels
            if (chance(50))
                w = MAX_WIDTH;
            else
                h = MAX_HEIGHT;
            add_header(offset, w, h, depth);
            add_filler($urandom_range(0, 40));
        end else if (pick < 86) begin
            // offset beyond the file
            offset = chance(40) ? 32'hFFFF_FFFF : $urandom_range(200, 100000);
            add_header(offset, w, h, depth);
            add_filler($urandom_range(5, 30));
        end else if (pick < 93) begin
            // file ends inside the header
            len = $urandom_range(1, HDR_LEN - 1);
            for (int i = 0; i < len; i++)
                add_byte(8'($urandom), i == 0, 1'b0);
        end else begin
            // noise with stray start and end marks
            len = $urandom_range(1, 30);
            for (int i = 0; i < len; i++)
                add_byte(8'($urandom), chance(12), chance(12));
        end
        closed = (pick < 86) ? chance(80) : (pick < 93);
        if (closed)
            stream[stream.size() - 1].closes = 1'b1;
        if (closed && chance(20))
            repeat ($urandom_range(1, 4)) add_byte(8'($urandom), 1'b0, chance(30));
    endtask

    // One byte transaction; push stays high across back-to-back bytes
    task automatic send_byte(input file_byte_t fb, input int gap);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push       <= 1'b1;
        data_byte  <= fb.value;
        file_start <= fb.opens;
        file_end   <= fb.closes;
        do @(posedge clk); while (full);
    endtask

    task automatic send_stream();
        bit burst;
        burst = chance(25);
        items_sent += stream.size();
        foreach (stream[i])
            send_byte(stream[i], (burst || chance(70)) ? 0 : idle_length());
        stream.delete();
    endtask

    task automatic hold_until_drained();
        push <= 1'b0;
        do @(posedge clk); while (results_owed != 0);
    endtask

    // Result side: random stalls, with calm stretches of steady popping
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pop <= 1'b0;
            stall_left = 0;
            calm_left  = 0;
        end else if (calm_left > 0) begin
            calm_left--;
            pop <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
            if (chance(3))
                calm_left = $urandom_range(50, 300);
            else if (chance(20))
                stall_left = idle_length();
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // no start mark after reset: parsed from byte 0, then cut short
        add_byte(8'h42, 1'b0, 1'b0);
        add_byte(8'h4D, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0);
        add_byte(8'h55, 1'b0, 1'b1);
        // bytes after an end mark are ignored
        add_byte(8'hAA, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b1);
        // one-byte file
        add_byte(8'hFF, 1'b1, 1'b1);
        // short file
        add_byte(8'h00, 1'b1, 1'b0);
        add_byte(8'h80, 1'b0, 1'b0);
        add_byte(8'h7F, 1'b0, 1'b1);
        // restart inside a header
        add_byte(8'h01, 1'b1, 1'b0);
        add_byte(8'hFE, 1'b1, 1'b0);
        add_byte(8'h00, 1'b0, 1'b1);
        send_stream();
        hold_until_drained();

        // random files
        while (items_sent < RANDOM_ITEMS) begin
            build_file();
            send_stream();
            if (chance(15))
                hold_until_drained();
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && results_owed == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* filelist.f */
sv/bsd_pkg.sv
sv/bsd_front.sv
sv/bsd_parser.sv
sv/bsd_result_queue.sv
sv/bmp_stream_decoder_unit.sv
sv/bsd_checker.sv
sim/bmp_stream_decoder_checker.sv
sim/bmp_stream_decoder_unit_test.sv
